[sv/hcv_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the Hough circle voter: sequencer states, item and
// register codes, reset values and the quarter-wave sine table (Q1.14).
// No dependencies.
package hcv_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_SCAN,
    ST_EMIT
  } hcv_state_t;

  // Item modes
  localparam logic [1:0] MODE_VOTE   = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_RADIUS_LO  = 3'd0;
  localparam logic [2:0] CFG_RADIUS_HI  = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD  = 3'd2;
  localparam logic [2:0] CFG_IMAGE_ROWS = 3'd3;
  localparam logic [2:0] CFG_IMAGE_COLS = 3'd4;

  // Register reset values
  localparam logic [7:0]  RADIUS_LO_RST  = 8'd10;
  localparam logic [7:0]  RADIUS_HI_RST  = 8'd25;
  localparam logic [15:0] THRESHOLD_RST  = 16'd126;
  localparam logic [6:0]  IMAGE_ROWS_RST = 7'd64;
  localparam logic [6:0]  IMAGE_COLS_RST = 7'd64;

  // Angle stepping within a quadrant
  localparam logic [6:0] QUARTER_LAST = 7'd89;
  localparam logic [6:0] QUARTER_DEG  = 7'd90;

  // round(16384 * sin(d)), d = 0..90 degrees
  localparam logic [14:0] QUARTER_SINE [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

endpackage

[sv/hough_circle_voter_top.sv]
`timescale 1ns / 1ps
// Vote item: one vote per cycle through a four-stage pipeline, radii * ANGLE_COUNT
//   votes in all (5776 with the reset radius range).
// Clear item: MAX_ROWS*MAX_COLS*RADIUS_SLOTS cells, one cell written per cycle.
// Report item: one cell examined per cycle from the cursor.
// Reset: synchronous; a clearing pass over all MAX_ROWS*MAX_COLS*RADIUS_SLOTS cells
//   (65536 by default) runs first, with items stalled. Depends on hcv_pkg.
module hough_circle_voter_top #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int RADIUS_SLOTS = 16,
  parameter int VOTE_WIDTH   = 16,
  parameter int ANGLE_COUNT  = 361
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  point_row,
  input  logic [5:0]  point_col,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        found,
  output logic [5:0]  center_row,
  output logic [5:0]  center_col,
  output logic [7:0]  radius,
  output logic [15:0] votes,
  output logic        scan_done,
  // register writes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hcv_pkg::*;

  localparam int RW         = $clog2(MAX_ROWS);
  localparam int CW         = $clog2(MAX_COLS);
  localparam int SW         = (RADIUS_SLOTS > 1) ? $clog2(RADIUS_SLOTS) : 1;
  localparam int TW         = $clog2(ANGLE_COUNT);
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS * RADIUS_SLOTS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int ROW_STRIDE = MAX_COLS * RADIUS_SLOTS;
  localparam int XW         = VOTE_WIDTH + 16;

  typedef struct packed {
    logic          past_end;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [SW-1:0] slot;
  } pos_t;

  // flat cell address of (row, col, slot)
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c,
                                              input logic [SW-1:0] s);
    cell_addr = AW'(r) * AW'(ROW_STRIDE) + AW'(c) * AW'(RADIUS_SLOTS) + AW'(s);
  endfunction

  // next cell in scan order, flags the step past the last cell
  function automatic pos_t pos_step(input pos_t p);
    pos_t n;
    n = p;
    if (p.slot == SW'(RADIUS_SLOTS - 1)) begin
      n.slot = '0;
      if (p.col == CW'(MAX_COLS - 1)) begin
        n.col = '0;
        if (p.row == RW'(MAX_ROWS - 1)) begin
          n.row      = '0;
          n.past_end = 1'b1;
        end else begin
          n.row = p.row + 1'b1;
        end
      end else begin
        n.col = p.col + 1'b1;
      end
    end else begin
      n.slot = p.slot + 1'b1;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [7:0]  radius_lo;
  logic [7:0]  radius_hi;
  logic [15:0] vote_threshold;
  logic [6:0]  image_rows;
  logic [6:0]  image_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_lo      <= RADIUS_LO_RST;
      radius_hi      <= RADIUS_HI_RST;
      vote_threshold <= THRESHOLD_RST;
      image_rows     <= IMAGE_ROWS_RST;
      image_cols     <= IMAGE_COLS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RADIUS_LO:  radius_lo      <= cfg_data[7:0];
        CFG_RADIUS_HI:  radius_hi      <= cfg_data[7:0];
        CFG_THRESHOLD:  vote_threshold <= cfg_data;
        CFG_IMAGE_ROWS: image_rows     <= cfg_data[6:0];
        CFG_IMAGE_COLS: image_cols     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // derived limits
  logic [8:0]  top_radius;
  logic [8:0]  hi_radius;
  logic        range_empty;
  logic [10:0] rows_eff;
  logic [10:0] cols_eff;

  assign top_radius  = {1'b0, radius_lo} + 9'(RADIUS_SLOTS - 1);
  assign hi_radius   = ({1'b0, radius_hi} < top_radius) ? {1'b0, radius_hi} : top_radius;
  assign range_empty = radius_hi < radius_lo;
  assign rows_eff    = (11'(image_rows) < 11'(MAX_ROWS)) ? 11'(image_rows) : 11'(MAX_ROWS);
  assign cols_eff    = (11'(image_cols) < 11'(MAX_COLS)) ? 11'(image_cols) : 11'(MAX_COLS);

  // ---------------------------------------------------------------- declarations
  hcv_state_t state, state_next;

  logic          accept;
  logic          out_free;
  logic          seq_issue;
  logic          scan_issue;
  logic          clr_active;
  logic          seq_last;
  logic          clr_last;
  logic          pipe_busy;
  logic          scan_hit;
  logic          scan_finish;

  logic [AW-1:0] clr_addr;
  logic [5:0]    pt_row;
  logic [5:0]    pt_col;

  // angle / radius sequencer
  logic [SW-1:0] slot;
  logic [TW-1:0] t_cnt;
  logic [1:0]    sin_q, cos_q;
  logic [6:0]    sin_m, cos_m;
  logic [8:0]    r_cur;
  logic [6:0]    sin_idx, cos_idx;

  // vote pipeline
  logic          p1v, p2v, p3v;
  logic [7:0]    p1_r;
  logic [SW-1:0] p1_slot, p2_slot;
  logic [14:0]   p1_cmag, p1_smag;
  logic          p1_cneg, p1_sneg, p2_dyneg, p2_dxneg;
  logic [22:0]   c_prod, s_prod;
  logic [8:0]    p2_dy, p2_dx;
  logic [10:0]   a_sum, b_sum;
  logic          in_img;
  logic [AW-1:0] vote_addr;
  logic [AW-1:0] p3_addr;

  // memory ports and forwarding
  logic [VOTE_WIDTH-1:0] mem [CELL_COUNT];
  logic [VOTE_WIDTH-1:0] mem_q;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VOTE_WIDTH-1:0] wr_data;
  logic                  fw_valid;
  logic [AW-1:0]         fw_addr;
  logic [VOTE_WIDTH-1:0] fw_data;
  logic [VOTE_WIDTH-1:0] cell_cur;
  logic [VOTE_WIDTH-1:0] cell_inc;

  // scan
  pos_t          cursor;
  pos_t          rq_pos;
  logic          rq_valid;
  logic [AW-1:0] scan_addr;
  logic [XW-1:0] vote_ext;

  // pending result
  logic        pend_found;
  logic [5:0]  pend_row;
  logic [5:0]  pend_col;
  logic [7:0]  pend_radius;
  logic [15:0] pend_votes;
  logic        pend_done;

  // ---------------------------------------------------------------- status
  assign accept      = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;
  assign r_cur       = {1'b0, radius_lo} + 9'(slot);
  assign seq_last    = (t_cnt == TW'(ANGLE_COUNT - 1)) && (r_cur == hi_radius);
  assign clr_last    = clr_addr == AW'(CELL_COUNT - 1);
  assign pipe_busy   = p1v || p2v || p3v;
  assign vote_ext    = {16'b0, mem_q};
  assign scan_hit    = rq_valid && (vote_ext > XW'(vote_threshold));
  assign scan_finish = scan_hit || cursor.past_end;

  // ---------------------------------------------------------------- state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_VOTE:   if (!range_empty) state_next = ST_VOTE;
            MODE_CLEAR:  state_next = ST_CLEAR;
            MODE_REPORT: state_next = ST_SCAN;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_VOTE:  if (seq_last) state_next = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_next = ST_IDLE;
      ST_SCAN:  if (scan_finish) state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // controls from state
  always_comb begin
    item_stall = (state != ST_IDLE);
    seq_issue  = (state == ST_VOTE);
    scan_issue = (state == ST_SCAN) && !cursor.past_end;
    clr_active = (state == ST_CLEAR);
  end

  // ---------------------------------------------------------------- clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (accept && mode == MODE_CLEAR) begin
      clr_addr <= '0;
    end else if (clr_active && !clr_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // edge point latch
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_VOTE) begin
      pt_row <= point_row;
      pt_col <= point_col;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      t_cnt <= '0;
      sin_q <= 2'd0;
      sin_m <= '0;
      cos_q <= 2'd1;
      cos_m <= '0;
    end else if (accept && mode == MODE_VOTE) begin
      slot  <= '0;
      t_cnt <= '0;
      sin_q <= 2'd0;
      sin_m <= '0;
      cos_q <= 2'd1;
      cos_m <= '0;
    end else if (seq_issue) begin
      if (t_cnt == TW'(ANGLE_COUNT - 1)) begin
        t_cnt <= '0;
        sin_q <= 2'd0;
        sin_m <= '0;
        cos_q <= 2'd1;
        cos_m <= '0;
        slot  <= slot + 1'b1;
      end else begin
        t_cnt <= t_cnt + 1'b1;
        if (sin_m == QUARTER_LAST) begin
          sin_m <= '0;
          sin_q <= sin_q + 1'b1;
        end else begin
          sin_m <= sin_m + 1'b1;
        end
        if (cos_m == QUARTER_LAST) begin
          cos_m <= '0;
          cos_q <= cos_q + 1'b1;
        end else begin
          cos_m <= cos_m + 1'b1;
        end
      end
    end
  end

  // quadrant fold: odd quadrants read the table backwards
  assign sin_idx = sin_q[0] ? (QUARTER_DEG - sin_m) : sin_m;
  assign cos_idx = cos_q[0] ? (QUARTER_DEG - cos_m) : cos_m;

  // ---------------------------------------------------------------- vote pipeline
  assign c_prod = 23'(p1_r) * 23'(p1_cmag);
  assign s_prod = 23'(p1_r) * 23'(p1_smag);

  // centre = point minus truncated offset, kept only inside the image
  assign a_sum  = p2_dyneg ? (11'(pt_row) + 11'(p2_dy)) : (11'(pt_row) - 11'(p2_dy));
  assign b_sum  = p2_dxneg ? (11'(pt_col) + 11'(p2_dx)) : (11'(pt_col) - 11'(p2_dx));
  assign in_img = !a_sum[10] && !b_sum[10] && (a_sum < rows_eff) && (b_sum < cols_eff);
  assign vote_addr = cell_addr(a_sum[RW-1:0], b_sum[CW-1:0], p2_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
    end else begin
      p1v <= seq_issue;
      p2v <= p1v;
      p3v <= p2v && in_img;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: table lookup
    p1_r    <= r_cur[7:0];
    p1_slot <= slot;
    p1_cmag <= QUARTER_SINE[cos_idx];
    p1_cneg <= cos_q[1];
    p1_smag <= QUARTER_SINE[sin_idx];
    p1_sneg <= sin_q[1];
    // stage 2: scaled offsets, Q1.14 dropped
    p2_slot  <= p1_slot;
    p2_dy    <= c_prod[22:14];
    p2_dyneg <= p1_cneg;
    p2_dx    <= s_prod[22:14];
    p2_dxneg <= p1_sneg;
    // stage 3: cell address, read issued
    p3_addr  <= vote_addr;
  end

  // stage 4: saturating increment, last write forwarded
  assign cell_cur = (fw_valid && fw_addr == p3_addr) ? fw_data : mem_q;
  assign cell_inc = (cell_cur == {VOTE_WIDTH{1'b1}}) ? cell_cur : cell_cur + 1'b1;

  // ---------------------------------------------------------------- memory
  assign rd_addr = (state == ST_SCAN) ? scan_addr : vote_addr;
  assign wr_en   = clr_active || p3v;
  assign wr_addr = clr_active ? clr_addr : p3_addr;
  assign wr_data = clr_active ? '0 : cell_inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fw_addr <= wr_addr;
    fw_data <= wr_data;
  end

  // ---------------------------------------------------------------- report scan
  assign scan_addr = cell_addr(cursor.row, cursor.col, cursor.slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      rq_valid <= 1'b0;
    end else begin
      rq_valid <= scan_issue && !scan_finish;
      priority if (accept && mode == MODE_CLEAR) begin
        cursor <= '0;
      end else if (state == ST_SCAN && scan_hit) begin
        cursor <= pos_step(rq_pos);
      end else if (state == ST_SCAN && cursor.past_end) begin
        cursor <= '0;
      end else if (scan_issue) begin
        cursor <= pos_step(cursor);
      end
    end
  end

  always_ff @(posedge clk) begin
    rq_pos <= cursor;
  end

  // result held until the output register frees
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan_finish) begin
      pend_found  <= scan_hit;
      pend_done   <= !scan_hit;
      pend_row    <= scan_hit ? 6'(rq_pos.row) : 6'd0;
      pend_col    <= scan_hit ? 6'(rq_pos.col) : 6'd0;
      pend_radius <= scan_hit ? (radius_lo + 8'(rq_pos.slot)) : 8'd0;
      pend_votes  <= scan_hit ? vote_ext[15:0] : 16'd0;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      found      <= pend_found;
      center_row <= pend_row;
      center_col <= pend_col;
      radius     <= pend_radius;
      votes      <= pend_votes;
      scan_done  <= pend_done;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !(p1v || p2v || p3v))
    else $error("vote pipeline busy while idle");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside emit");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !wr_en)
    else $error("accumulator written during scan");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> wr_en && wr_data == '0)
    else $error("clearing pass not writing zero");

endmodule

[dv/hough_circle_voter_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hough_circle_voter_top: drives vote, clear and report items,
// keeps its own copy of the vote accumulator and checks every report result field by field.
// Depends on hcv_pkg and hough_circle_voter_top.
module hough_circle_voter_top_tb;
  import hcv_pkg::*;

  localparam int GRID_ROWS  = 64;
  localparam int GRID_COLS  = 64;
  localparam int SLOTS      = 16;
  localparam int ANGLES     = 361;
  localparam int CELL_TOTAL = GRID_ROWS * GRID_COLS * SLOTS;
  localparam int IDLE_LIMIT = 400000;
  localparam int ROUNDS     = 6;
  localparam int LONG_HOLD  = 4000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic        found;
    logic [5:0]  center_row;
    logic [5:0]  center_col;
    logic [7:0]  radius;
    logic [15:0] votes;
    logic        scan_done;
  } circle_report_t;

  // Accumulator copy, register copy and the queue of reports still owed
  class circle_vote_tracker;
    bit [15:0]      cells [CELL_TOTAL];
    int             cursor;
    int             min_r, max_r, threshold, rows_used, cols_used;
    circle_report_t pending [$];
    int             busy_tail;
    int             fails, votes_cast, found_count, done_count, reg_writes;

    function new();
      cursor    = 0;
      min_r     = RADIUS_LO_RST;
      max_r     = RADIUS_HI_RST;
      threshold = THRESHOLD_RST;
      rows_used = IMAGE_ROWS_RST;
      cols_used = IMAGE_COLS_RST;
      busy_tail = 16;
    endfunction

    // Q1.14 sine of whole degrees, built from the quarter-wave table
    function int sine_q14(int deg);
      int d, m, q;
      d = deg % 360;
      m = d % 90;
      case (d / 90)
        0: q = QUARTER_SINE[m];
        1: q = QUARTER_SINE[90 - m];
        2: q = -int'(QUARTER_SINE[m]);
        default: q = -int'(QUARTER_SINE[90 - m]);
      endcase
      return q;
    endfunction

    // r * c / 2^14, rounded toward zero
    function int trunc_scaled(int r, int c);
      int v;
      v = (r * ((c < 0) ? -c : c)) >>> 14;
      return (c < 0) ? -v : v;
    endfunction

    // largest radius actually voted for
    function int slot_top();
      int top;
      top = min_r + SLOTS - 1;
      return (max_r < top) ? max_r : top;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      reg_writes++;
      case (idx)
        CFG_RADIUS_LO:  min_r     = int'(data[7:0]);
        CFG_RADIUS_HI:  max_r     = int'(data[7:0]);
        CFG_THRESHOLD:  threshold = int'(data);
        CFG_IMAGE_ROWS: rows_used = int'(data[6:0]);
        CFG_IMAGE_COLS: cols_used = int'(data[6:0]);
        default: ;
      endcase
    endfunction

    function void cast_votes(int row, int col);
      int rows, cols, a, b, idx;
      rows = (rows_used < GRID_ROWS) ? rows_used : GRID_ROWS;
      cols = (cols_used < GRID_COLS) ? cols_used : GRID_COLS;
      for (int r = min_r; r <= slot_top(); r++) begin
        for (int t = 0; t < ANGLES; t++) begin
          a = row - trunc_scaled(r, sine_q14(t + 90));
          b = col - trunc_scaled(r, sine_q14(t));
          // centres off the image are dropped
          if (a < 0 || b < 0 || a >= rows || b >= cols) continue;
          idx = (a * GRID_COLS + b) * SLOTS + (r - min_r);
          if (cells[idx] != 16'hFFFF) cells[idx]++;
          votes_cast++;
        end
      end
    endfunction

    // Apply one accepted item; a report queues the result it must produce
    function void note_item(logic [1:0] m, logic [5:0] row, logic [5:0] col);
      circle_report_t rep;
      int i;
      busy_tail = 16;
      case (m)
        MODE_VOTE: begin
          if (slot_top() >= min_r) busy_tail += (slot_top() - min_r + 1) * ANGLES;
          cast_votes(int'(row), int'(col));
        end
        MODE_CLEAR: begin
          foreach (cells[k]) cells[k] = '0;
          cursor = 0;
          busy_tail += CELL_TOTAL;
        end
        MODE_REPORT: begin
          rep = '0;
          for (i = cursor; i < CELL_TOTAL; i++)
            if (int'(cells[i]) > threshold) break;
          if (i < CELL_TOTAL) begin
            rep.found      = 1'b1;
            rep.center_row = 6'((i / SLOTS) / GRID_COLS);
            rep.center_col = 6'((i / SLOTS) % GRID_COLS);
            rep.radius     = 8'(min_r + i % SLOTS);
            rep.votes      = cells[i];
            cursor = i + 1;
            found_count++;
          end else begin
            // nothing left: rewind
            rep.scan_done = 1'b1;
            cursor = 0;
            done_count++;
          end
          pending.insert(pending.size(), rep);
        end
        default: ;
      endcase
    endfunction

    function bit field_ok(string name, int want, int got);
      if (want == got) return 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_report(circle_report_t got);
      circle_report_t want;
      bit ok;
      if (pending.size() == 0) begin
        $display("%0t: report result with no report outstanding", $time);
        fails++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      ok = field_ok("found", want.found, got.found);
      ok &= field_ok("center_row", want.center_row, got.center_row);
      ok &= field_ok("center_col", want.center_col, got.center_col);
      ok &= field_ok("radius", want.radius, got.radius);
      ok &= field_ok("votes", want.votes, got.votes);
      ok &= field_ok("scan_done", want.scan_done, got.scan_done);
      if (!ok) fails++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  mode;
  logic [5:0]  point_row;
  logic [5:0]  point_col;
  logic        result_valid;
  logic        result_stall;
  logic        found;
  logic [5:0]  center_row;
  logic [5:0]  center_col;
  logic [7:0]  radius;
  logic [15:0] votes;
  logic        scan_done;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  circle_vote_tracker tracker = new();
  bit calm;
  bit hold_results;
  int items_sent;

  hough_circle_voter_top i_dut (.*);

  always #6 clk = ~clk;

  // Check every accepted report result
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.check_report(circle_report_t'({found, center_row, center_col, radius,
                                              votes, scan_done}));
  end

  // Watchdog: too long with no item or result moving
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL hough_circle_voter_top");
    $finish;
  end

  // Receiver: runs of ready and stalled cycles, plus one long hold on request
  initial begin
    int hold_left, run_left;
    bit run_stall;
    hold_left = 0;
    run_left = 0;
    run_stall = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        result_stall <= run_stall && !calm;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  begin run_stall = 1'b0; run_left = $urandom_range(1, 4);   end
          [60:91]: begin run_stall = 1'b1; run_left = $urandom_range(1, 3);   end
          default: begin run_stall = 1'b1; run_left = $urandom_range(20, 80); end
        endcase
        result_stall <= run_stall && !calm;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic int clamp_grid(int v);
    return (v < 0) ? 0 : ((v > GRID_ROWS - 1) ? GRID_ROWS - 1 : v);
  endfunction

  // Offer one item after an optional gap; returns at the falling edge after acceptance
  // with valid still high, so the caller either sends again or lowers it.
  task automatic send_item(input logic [1:0] m, input logic [5:0] row,
                           input logic [5:0] col, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    point_row <= row;
    point_col <= col;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.note_item(m, row, col);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_reports_drained();
    item_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Block idle: all reports back and the last item worked off
  task automatic settle_block();
    wait_reports_drained();
    repeat (tracker.busy_tail) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] minr, input logic [15:0] maxr,
                              input logic [15:0] thr, input logic [15:0] rows,
                              input logic [15:0] cols);
    put_reg(CFG_RADIUS_LO, minr);
    put_reg(CFG_RADIUS_HI, maxr);
    put_reg(CFG_THRESHOLD, thr);
    put_reg(CFG_IMAGE_ROWS, rows);
    put_reg(CFG_IMAGE_COLS, cols);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int minr, maxr, thr, rows, cols, cr, cc, rad, ang, prow, pcol, kind;
    rst = 1'b1;
    item_valid = 1'b0;
    mode = MODE_VOTE;
    point_row = '0;
    point_col = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_RADIUS_LO;
    cfg_data = '0;
    calm = 1'b0;
    hold_results = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: corner points, high threshold so the report runs off the end
    send_item(MODE_VOTE, 6'd0, 6'd0, pick_gap());
    send_item(MODE_VOTE, 6'd63, 6'd63, pick_gap());
    send_item(MODE_VOTE, 6'd32, 6'd21, pick_gap());
    send_item(MODE_REPORT, 6'd0, 6'd0, pick_gap());
    send_item(MODE_UNUSED, 6'd63, 6'd63, pick_gap());

    // Threshold zero, radius from zero, max radius clamped; clear mid-way
    settle_block();
    program_regs(16'd0, 16'd255, 16'd0, 16'd64, 16'd64);
    repeat (3) send_item(MODE_REPORT, 6'd63, 6'd0, pick_gap());
    send_item(MODE_VOTE, 6'd63, 6'd0, pick_gap());
    send_item(MODE_CLEAR, 6'd63, 6'd63, pick_gap());
    send_item(MODE_VOTE, 6'd0, 6'd63, pick_gap());
    repeat (2) send_item(MODE_REPORT, 6'd0, 6'd0, pick_gap());

    // Empty radius range; radius reported against the new minimum
    settle_block();
    program_regs(16'd5, 16'd3, 16'd2, 16'd127, 16'd127);
    send_item(MODE_VOTE, 6'd31, 6'd31, pick_gap());
    repeat (2) send_item(MODE_REPORT, 6'd31, 6'd31, pick_gap());

    // Zero image rows: no centre can be valid
    settle_block();
    program_regs(16'd2, 16'd6, 16'd1, 16'd0, 16'd64);
    send_item(MODE_VOTE, 6'd40, 6'd20, pick_gap());
    send_item(MODE_REPORT, 6'd40, 6'd20, pick_gap());

    // Top radius, top threshold, upper data bits ignored, tiny image
    settle_block();
    program_regs(16'hA5FF, 16'd255, 16'hFFFF, 16'hFF91, 16'h0F81);
    send_item(MODE_VOTE, 6'd5, 6'd5, pick_gap());
    send_item(MODE_REPORT, 6'd5, 6'd5, pick_gap());

    // Random rounds: edge points around one circle, some noise, reports
    for (int round = 0; round < ROUNDS; round++) begin
      settle_block();
      calm = (round == 4);
      minr = $urandom_range(0, 40);
      maxr = (round == 2) ? 255 : minr + $urandom_range(0, 3);
      thr  = (round == 0) ? 0 : $urandom_range(0, 6);
      rows = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64) : 64;
      cols = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64) : 64;
      program_regs(16'(minr), 16'(maxr), 16'(thr), 16'(rows), 16'(cols));
      if (round == 1 || round == 3)
        send_item(MODE_CLEAR, 6'($urandom), 6'($urandom), pick_gap());
      cr = $urandom_range(8, 55);
      cc = $urandom_range(8, 55);
      rad = minr + $urandom_range(0, tracker.slot_top() - minr);
      for (int k = 0; k < 13; k++) begin
        if (round == 0 && k == 8) begin
          // receiver holds off while reports keep coming, filling the block
          settle_block();
          hold_results = 1'b1;
          repeat (4) send_item(MODE_REPORT, 6'($urandom), 6'($urandom), 0);
        end
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          ang  = $urandom_range(0, 359);
          prow = clamp_grid(cr + tracker.trunc_scaled(rad, tracker.sine_q14(ang + 90)));
          pcol = clamp_grid(cc + tracker.trunc_scaled(rad, tracker.sine_q14(ang)));
          send_item(MODE_VOTE, 6'(prow), 6'(pcol), pick_gap());
        end else if (kind < 62) begin
          send_item(MODE_VOTE, 6'($urandom), 6'($urandom), pick_gap());
        end else if (kind < 66) begin
          send_item(MODE_UNUSED, 6'($urandom), 6'($urandom), pick_gap());
        end else begin
          send_item(MODE_REPORT, 6'($urandom), 6'($urandom), pick_gap());
        end
        if ($urandom_range(0, 19) == 0) wait_reports_drained();
      end
    end

    settle_block();
    $display("Run covered %0d items over %0d register settings, %0d votes landed.",
             items_sent, tracker.reg_writes / 5, tracker.votes_cast);
    $display("Reports checked: %0d circles found, %0d scans run to the end, %0d failures.",
             tracker.found_count, tracker.done_count, tracker.fails);
    if (tracker.fails == 0) begin
      $display("PASS hough_circle_voter_top");
    end else begin
      $display("FAIL hough_circle_voter_top");
    end
    $finish;
  end

endmodule

[sim.f]
sv/hcv_pkg.sv
sv/hough_circle_voter_top.sv
dv/hough_circle_voter_top_tb.sv
